// ===== hdl/lte_pkg.sv =====
// shared types, constants and rate table for the link throughput estimator
package lte_pkg;

  localparam int CNT_W   = 32;
  localparam int RATE_W  = 9;
  localparam int PROD_W  = 39;
  localparam int STEP_W  = 6;
  localparam int PC_W    = 4;
  localparam int PHY_W   = 15;
  localparam int LOSS_W  = 7;
  localparam int TPUT_W  = 21;

  localparam logic [STEP_W-1:0] DIV_STEPS = 6'd39;

  // divide by 100 as multiply by ceil(2^28/100) and shift, exact below 2^21
  localparam int                SCL_W   = 21;
  localparam int                RCP_W   = 22;
  localparam int                RCP_SH  = 28;
  localparam logic [RCP_W-1:0]  RCP_100 = 22'd2684355;

  localparam logic [7:0]        DEFAULT_MCS  = 8'hFF;
  localparam logic [2:0]        DEFAULT_BW   = 3'd2;
  localparam logic [TPUT_W-1:0] DEFAULT_TPUT = 21'd95000;
  localparam logic [13:0]       FALLBACK_PHY = 14'd1950;

  // multiplier operand a
  localparam logic [1:0] A_DIFF = 2'd0;
  localparam logic [1:0] A_PHY  = 2'd1;
  localparam logic [1:0] A_QUO  = 2'd2;

  // multiplier operand b
  localparam logic [2:0] B_100  = 3'd0;
  localparam logic [2:0] B_GI   = 3'd1;
  localparam logic [2:0] B_70   = 3'd2;
  localparam logic [2:0] B_KEEP = 3'd3;
  localparam logic [2:0] B_125  = 3'd4;

  // jump conditions
  localparam logic [1:0] JC_NONE   = 2'd0;
  localparam logic [1:0] JC_ALWAYS = 2'd1;
  localparam logic [1:0] JC_NOSTAT = 2'd2;
  localparam logic [1:0] JC_LOOP   = 2'd3;

  // program steps
  localparam logic [PC_W-1:0] PC_IDLE   = 4'd0;
  localparam logic [PC_W-1:0] PC_START  = 4'd1;
  localparam logic [PC_W-1:0] PC_DIV1   = 4'd2;
  localparam logic [PC_W-1:0] PC_GI     = 4'd3;
  localparam logic [PC_W-1:0] PC_DIV2   = 4'd4;
  localparam logic [PC_W-1:0] PC_MAC    = 4'd5;
  localparam logic [PC_W-1:0] PC_DIV3   = 4'd6;
  localparam logic [PC_W-1:0] PC_LOSS   = 4'd7;
  localparam logic [PC_W-1:0] PC_DIV4   = 4'd8;
  localparam logic [PC_W-1:0] PC_BYTES  = 4'd9;
  localparam logic [PC_W-1:0] PC_EMIT   = 4'd10;
  localparam logic [PC_W-1:0] PC_DEFLT  = 4'd11;

  typedef struct packed {
    logic            mul_en;
    logic [1:0]      mul_a;
    logic [2:0]      mul_b;
    logic            div_step;
    logic            rcp_ld;
    logic            loss_ld;
    logic            emit;
    logic            emit_def;
    logic [1:0]      jc;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic nostat;
    logic cnt_more;
    logic out_busy;
  } status_t;

  function automatic logic [13:0] rate_table_kbps(input logic [3:0] mcs);
    logic [13:0] r;
    case (mcs)
      4'd0:    r = 14'd650;
      4'd1:    r = 14'd1300;
      4'd2:    r = 14'd1950;
      4'd3:    r = 14'd2600;
      4'd4:    r = 14'd3900;
      4'd5:    r = 14'd5200;
      4'd6:    r = 14'd5850;
      4'd7:    r = 14'd6500;
      4'd8:    r = 14'd7800;
      4'd9:    r = 14'd8667;
      default: r = FALLBACK_PHY;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/lte_sequencer.sv =====
// step counter and microcode rom for the closing computation
module lte_sequencer (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  lte_pkg::status_t status,
  output lte_pkg::ctrl_t   ctrl,
  output logic             idle
);
  import lte_pkg::*;

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            jump;

  function automatic ctrl_t rom(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '0;
    w.jc = JC_NONE;
    w.target = PC_IDLE;
    case (pc)
      PC_IDLE: begin
        w.jc = JC_ALWAYS;
      end
      PC_START: begin
        w.mul_en = 1'b1; w.mul_a = A_DIFF; w.mul_b = B_100;
        w.jc = JC_NOSTAT; w.target = PC_DEFLT;
      end
      PC_DIV1: begin
        w.div_step = 1'b1;
        w.jc = JC_LOOP; w.target = PC_DIV1;
      end
      PC_GI: begin
        w.loss_ld = 1'b1;
        w.mul_en = 1'b1; w.mul_a = A_PHY; w.mul_b = B_GI;
      end
      PC_DIV2: begin
        w.rcp_ld = 1'b1;
      end
      PC_MAC: begin
        w.mul_en = 1'b1; w.mul_a = A_QUO; w.mul_b = B_70;
      end
      PC_DIV3: begin
        w.rcp_ld = 1'b1;
      end
      PC_LOSS: begin
        w.mul_en = 1'b1; w.mul_a = A_QUO; w.mul_b = B_KEEP;
      end
      PC_DIV4: begin
        w.rcp_ld = 1'b1;
      end
      PC_BYTES: begin
        w.mul_en = 1'b1; w.mul_a = A_QUO; w.mul_b = B_125;
      end
      PC_EMIT: begin
        w.emit = 1'b1;
        w.jc = JC_ALWAYS; w.target = PC_IDLE;
      end
      PC_DEFLT: begin
        w.emit_def = 1'b1;
        w.jc = JC_ALWAYS; w.target = PC_IDLE;
      end
      default: begin
        w.jc = JC_ALWAYS;
      end
    endcase
    return w;
  endfunction

  assign ctrl = rom(pc_r);
  assign idle = (pc_r == PC_IDLE);

  always_comb begin
    case (ctrl.jc)
      JC_ALWAYS: jump = 1'b1;
      JC_NOSTAT: jump = status.nostat;
      JC_LOOP:   jump = status.cnt_more;
      default:   jump = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt = pc_r;
    if (pc_r == PC_IDLE) begin
      if (start) begin
        pc_nxt = PC_START;
      end
    end else if ((ctrl.emit || ctrl.emit_def) && status.out_busy) begin
      pc_nxt = pc_r;
    end else if (jump) begin
      pc_nxt = ctrl.target;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== hdl/lte_datapath.sv =====
// best-entry registers, shared multiplier, serial divider, reciprocal scaler and result registers
module lte_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_take,
  input  logic [lte_pkg::CNT_W-1:0]     in_sent,
  input  logic [lte_pkg::CNT_W-1:0]     in_success,
  input  logic [lte_pkg::RATE_W-1:0]    in_rate,
  input  logic                          in_present,
  input  lte_pkg::ctrl_t                ctrl,
  output lte_pkg::status_t              status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_mcs,
  output logic [2:0]                    out_bw,
  output logic                          out_sg,
  output logic [lte_pkg::LOSS_W-1:0]    out_loss,
  output logic [lte_pkg::TPUT_W-1:0]    out_tput
);
  import lte_pkg::*;

  logic [CNT_W-1:0]  best_sent_r, best_succ_r;
  logic [RATE_W-1:0] best_rate_r;
  logic [PROD_W-1:0] dvd_r;
  logic [CNT_W-1:0]  rem_r;
  logic [STEP_W-1:0] cnt_r;
  logic [LOSS_W-1:0] loss_r;
  logic              out_valid_r;
  logic [7:0]        out_mcs_r;
  logic [2:0]        out_bw_r;
  logic              out_sg_r;
  logic [LOSS_W-1:0] out_loss_r;
  logic [TPUT_W-1:0] out_tput_r;

  logic [CNT_W-1:0]  diff;
  logic [13:0]       phy_base;
  logic [PHY_W-1:0]  phy;
  logic [CNT_W-1:0]  mul_a;
  logic [6:0]        mul_b;
  logic [PROD_W-1:0] product;
  logic [SCL_W+RCP_W-1:0] rcp_prod;
  logic [CNT_W-1:0]  divisor;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    sub;
  logic              ge;
  logic              fire;
  logic [3:0]        bw_code;
  logic [2:0]        bw_mhz;

  assign diff = (best_succ_r >= best_sent_r) ? '0 : (best_sent_r - best_succ_r);

  assign bw_code  = best_rate_r[3:0];
  assign phy_base = rate_table_kbps(best_rate_r[7:4]);

  always_comb begin
    case (bw_code)
      4'd0:    begin phy = {2'b00, phy_base[13:1]}; bw_mhz = 3'd1; end
      4'd1:    begin phy = {1'b0, phy_base};        bw_mhz = 3'd2; end
      default: begin phy = {phy_base, 1'b0};        bw_mhz = 3'd4; end
    endcase
  end

  always_comb begin
    case (ctrl.mul_a)
      A_DIFF:  mul_a = diff;
      A_PHY:   mul_a = {{(CNT_W-PHY_W){1'b0}}, phy};
      default: mul_a = {{(CNT_W-PHY_W){1'b0}}, dvd_r[PHY_W-1:0]};
    endcase
    case (ctrl.mul_b)
      B_100:   mul_b = 7'd100;
      B_GI:    mul_b = best_rate_r[8] ? 7'd111 : 7'd100;
      B_70:    mul_b = 7'd70;
      B_KEEP:  mul_b = 7'd100 - loss_r;
      default: mul_b = 7'd125;
    endcase
  end

  assign product = {7'd0, mul_a} * {32'd0, mul_b};

  assign rcp_prod = {{RCP_W{1'b0}}, dvd_r[SCL_W-1:0]} * {{SCL_W{1'b0}}, RCP_100};

  assign divisor = best_sent_r;
  assign shifted = {rem_r, dvd_r[PROD_W-1]};
  assign ge      = (shifted >= {1'b0, divisor});
  assign sub     = shifted - {1'b0, divisor};

  assign fire = (ctrl.emit || ctrl.emit_def) && !(out_valid_r && !out_ready);

  assign status.nostat   = (best_sent_r == '0);
  assign status.cnt_more = (cnt_r != 6'd1);
  assign status.out_busy = out_valid_r && !out_ready;

  // best entry, cleared after each result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_sent_r <= '0;
      best_succ_r <= '0;
      best_rate_r <= '0;
    end else if (fire) begin
      best_sent_r <= '0;
      best_succ_r <= '0;
      best_rate_r <= '0;
    end else if (in_take && in_present && (in_sent > best_sent_r)) begin
      best_sent_r <= in_sent;
      best_succ_r <= in_success;
      best_rate_r <= in_rate;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctrl.mul_en) begin
      cnt_r <= DIV_STEPS;
    end else if (ctrl.div_step) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      dvd_r <= product;
      rem_r <= '0;
    end else if (ctrl.div_step) begin
      dvd_r <= {dvd_r[PROD_W-2:0], ge};
      rem_r <= ge ? sub[CNT_W-1:0] : shifted[CNT_W-1:0];
    end else if (ctrl.rcp_ld) begin
      dvd_r <= {{(PROD_W-PHY_W){1'b0}}, rcp_prod[RCP_SH +: PHY_W]};
    end
    if (ctrl.loss_ld) begin
      loss_r <= dvd_r[LOSS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (ctrl.emit_def) begin
        out_mcs_r  <= DEFAULT_MCS;
        out_bw_r   <= DEFAULT_BW;
        out_sg_r   <= 1'b0;
        out_loss_r <= '0;
        out_tput_r <= DEFAULT_TPUT;
      end else begin
        out_mcs_r  <= {4'd0, best_rate_r[7:4]};
        out_bw_r   <= bw_mhz;
        out_sg_r   <= best_rate_r[8];
        out_loss_r <= loss_r;
        out_tput_r <= dvd_r[TPUT_W-1:0];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_mcs   = out_mcs_r;
  assign out_bw    = out_bw_r;
  assign out_sg    = out_sg_r;
  assign out_loss  = out_loss_r;
  assign out_tput  = out_tput_r;

endmodule

// ===== hdl/link_throughput_estimator.sv =====
// top level of the link throughput estimator
//
//   channel  direction  words
//   in_      input      one statistics table entry per word
//   out_     output     one throughput estimate per table
//
// an entry that is not marked last is taken whenever the program is idle
// a last entry runs the microcode program and holds in_ready low while it runs:
// serial divider steps for the loss percent and single steps, or only a start
// step and a default step when nothing was sent
// rst_n is synchronous and clears the kept entry, step counter and output valid
// the result waits in the output register; a stalled output holds the program
// at its emit step while further entries are not taken
module link_throughput_estimator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lte_pkg::CNT_W-1:0]     in_sent_count,
  input  logic [lte_pkg::CNT_W-1:0]     in_success_count,
  input  logic [lte_pkg::RATE_W-1:0]    in_rate_word,
  input  logic                          in_entry_present,
  input  logic                          in_last_entry,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_mcs_index,
  output logic [2:0]                    out_bandwidth_mhz,
  output logic                          out_short_guard,
  output logic [lte_pkg::LOSS_W-1:0]    out_loss_percent,
  output logic [lte_pkg::TPUT_W-1:0]    out_throughput_bytes_per_s
);
  import lte_pkg::*;

  ctrl_t   ctrl;
  status_t status;
  logic    idle;
  logic    in_take;

  assign in_ready = idle;
  assign in_take  = in_valid && idle;

  lte_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_take && in_last_entry),
    .status (status),
    .ctrl   (ctrl),
    .idle   (idle)
  );

  lte_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_take    (in_take),
    .in_sent    (in_sent_count),
    .in_success (in_success_count),
    .in_rate    (in_rate_word),
    .in_present (in_entry_present),
    .ctrl       (ctrl),
    .status     (status),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_mcs    (out_mcs_index),
    .out_bw     (out_bandwidth_mhz),
    .out_sg     (out_short_guard),
    .out_loss   (out_loss_percent),
    .out_tput   (out_throughput_bytes_per_s)
  );

endmodule
